// ===== src/hhfs_pkg.sv =====
// Package for the HTTP header field scanner: character codes, event codes
// and the result record layout. No dependencies.
`default_nettype none

package hhfs_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam int FIELD_W = 16;
	localparam int TDATA_W = 72;

	typedef enum logic [2:0] {
		EV_PAIR        = 3'd0,
		EV_END         = 3'd1,
		EV_NO_LF       = 3'd2,
		EV_SPACES      = 3'd3,
		EV_NO_FINAL_LF = 3'd4
	} event_t;

	// Packed so that name_start lands in the lowest bits of tdata.
	typedef struct packed {
		logic [TDATA_W-65-1:0] pad;
		logic [FIELD_W-1:0]    value_stop;
		logic [FIELD_W-1:0]    value_start;
		logic                  has_colon;
		logic [FIELD_W-1:0]    name_stop;
		logic [FIELD_W-1:0]    name_start;
	} pair_rec_t;

	localparam int MAX_RUN_DEFAULT = 32;

endpackage

`default_nettype wire

// ===== src/http_header_field_scanner.sv =====
// HTTP header field scanner top level: byte stream in, pair/end/error items out.
// Depends on hhfs_pkg.
`default_nettype none

// Takes one header byte per cycle on s_axis and reports one item per header
// line on m_axis: a pair record on each CR, a header-end item on LF CR LF, or an
// error item, after which the block stays silent until reset. Sustained rate is
// one byte per clock while m_axis takes items, set by the per-byte state update
// between the input register and the result register; a byte's item is
// registered in the result register after the input register. Input stalls
// only while an item waits on m_axis and the input register holds a byte.
// Positions count bytes from reset modulo 2^POS_WIDTH and are shown in 16-bit
// fields. cfg_data sets the allowed space/tab run after the colon and should
// only be written while the block is idle.
module http_header_field_scanner #(
	parameter int POS_WIDTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] byte_in
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [15:0] name_start, [31:16] name_stop, [32] has_colon,
	// [48:33] value_start, [64:49] value_stop, [71:65] zero
	output logic [hhfs_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // [2:0] event_res
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_data        // [7:0] max_space_run
);

	typedef enum logic [2:0] {
		PH_EXPECT_LF,
		PH_AFTER_LF,
		PH_NAME,
		PH_SKIP,
		PH_VALUE,
		PH_FINAL_LF,
		PH_HALT
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [POS_WIDTH-1:0]   pos_q;
	logic [POS_WIDTH-1:0]   name_start_q, name_start_d;
	logic [POS_WIDTH-1:0]   colon_pos_q, colon_pos_d;
	logic [POS_WIDTH-1:0]   value_start_q, value_start_d;
	logic                   colon_seen_q, colon_seen_d;
	logic [7:0]             space_run_q, space_run_d;
	logic [7:0]             max_run_q;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;

	logic                   out_valid_q;
	hhfs_pkg::pair_rec_t    out_rec_q;
	hhfs_pkg::event_t       out_ev_q;

	logic                   emit_c;
	logic                   pair_c;
	hhfs_pkg::event_t       ev_c;
	hhfs_pkg::pair_rec_t    rec_c;
	logic [8:0]             run_next;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign run_next      = {1'b0, space_run_q} + 9'd1;

	always_comb begin
		phase_d       = phase_q;
		name_start_d  = name_start_q;
		colon_pos_d   = colon_pos_q;
		value_start_d = value_start_q;
		colon_seen_d  = colon_seen_q;
		space_run_d   = space_run_q;
		emit_c        = 1'b0;
		pair_c        = 1'b0;
		ev_c          = hhfs_pkg::EV_PAIR;
		unique case (phase_q)
			PH_EXPECT_LF: begin
				if (byte_s1 == hhfs_pkg::CH_LF) begin
					phase_d = PH_AFTER_LF;
				end else begin
					emit_c  = 1'b1;
					ev_c    = hhfs_pkg::EV_NO_LF;
					phase_d = PH_HALT;
				end
			end
			PH_AFTER_LF: begin
				if (byte_s1 == hhfs_pkg::CH_CR) begin
					phase_d = PH_FINAL_LF;
				end else begin
					name_start_d = pos_q;
					phase_d      = PH_NAME;
				end
			end
			PH_NAME: begin
				if (byte_s1 == hhfs_pkg::CH_CR) begin
					pair_c = 1'b1;
				end else if (byte_s1 == hhfs_pkg::CH_COLON) begin
					colon_pos_d  = pos_q;
					colon_seen_d = 1'b1;
					space_run_d  = '0;
					phase_d      = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (byte_s1 == hhfs_pkg::CH_SPACE || byte_s1 == hhfs_pkg::CH_TAB) begin
					if (run_next > {1'b0, max_run_q}) begin
						emit_c  = 1'b1;
						ev_c    = hhfs_pkg::EV_SPACES;
						phase_d = PH_HALT;
					end else begin
						space_run_d = run_next[7:0];
					end
				end else begin
					value_start_d = pos_q;
					// an empty value closes its line right here
					if (byte_s1 == hhfs_pkg::CH_CR) begin
						pair_c = 1'b1;
					end else begin
						phase_d = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				if (byte_s1 == hhfs_pkg::CH_CR) begin
					pair_c = 1'b1;
				end
			end
			PH_FINAL_LF: begin
				emit_c  = 1'b1;
				ev_c    = (byte_s1 == hhfs_pkg::CH_LF) ? hhfs_pkg::EV_END
				                                       : hhfs_pkg::EV_NO_FINAL_LF;
				phase_d = PH_HALT;
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase
		if (pair_c) begin
			emit_c       = 1'b1;
			colon_seen_d = 1'b0;
			phase_d      = PH_EXPECT_LF;
		end
		// end and error items carry all-zero fields
		rec_c = '0;
		if (pair_c) begin
			rec_c.name_start = hhfs_pkg::FIELD_W'(name_start_q);
			rec_c.value_stop = hhfs_pkg::FIELD_W'(pos_q);
			rec_c.has_colon  = colon_seen_q;
			if (colon_seen_q) begin
				rec_c.name_stop   = hhfs_pkg::FIELD_W'(colon_pos_q);
				rec_c.value_start = hhfs_pkg::FIELD_W'(value_start_d);
			end
		end
	end

	// control state, stage 1 and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_EXPECT_LF;
			pos_q         <= '0;
			name_start_q  <= '0;
			colon_pos_q   <= '0;
			value_start_q <= '0;
			colon_seen_q  <= 1'b0;
			space_run_q   <= '0;
			max_run_q     <= 8'(hhfs_pkg::MAX_RUN_DEFAULT);
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_run_q <= cfg_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				phase_q       <= phase_d;
				pos_q         <= pos_q + POS_WIDTH'(1);
				name_start_q  <= name_start_d;
				colon_pos_q   <= colon_pos_d;
				value_start_q <= value_start_d;
				colon_seen_q  <= colon_seen_d;
				space_run_q   <= space_run_d;
				out_valid_q   <= emit_c;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && emit_c) begin
			out_ev_q  <= ev_c;
			out_rec_q <= rec_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_rec_q;
	assign m_axis_tuser  = out_ev_q;

endmodule

`default_nettype wire

// ===== src/hhfs_checker.sv =====
// Port-level checker for http_header_field_scanner, with its bind statement.
// Depends on hhfs_pkg.
`default_nettype none

module hhfs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [hhfs_pkg::TDATA_W-1:0] m_axis_tdata,
	input wire [2:0]  m_axis_tuser
);

	logic halted_q;
	hhfs_pkg::pair_rec_t rec;

	assign rec = m_axis_tdata;

	// set once the final (end or error) item has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready
		             && m_axis_tuser != hhfs_pkg::EV_PAIR) begin
			halted_q <= 1'b1;
		end
	end

	a_silent_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !m_axis_tvalid)
		else $error("item after header end or error");

	a_non_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != hhfs_pkg::EV_PAIR) |-> (m_axis_tdata == '0))
		else $error("end or error item carries nonzero fields");

	a_no_colon_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == hhfs_pkg::EV_PAIR && !rec.has_colon)
		|-> (rec.name_stop == '0 && rec.value_start == '0))
		else $error("pair without colon has colon fields");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while output is free");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output item changed");

endmodule

bind http_header_field_scanner hhfs_checker u_hhfs_checker (.*);

`default_nettype wire

// ===== verif/http_header_field_scanner_tb.sv =====
// Self-checking testbench for http_header_field_scanner: random header lines
// through the byte stream, line records checked against an in-bench scanner model.
// Depends on hhfs_pkg and the http_header_field_scanner RTL.
`timescale 1ns / 100ps

module http_header_field_scanner_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum {
		SCAN_EXPECT_LF,
		SCAN_AFTER_LF,
		SCAN_NAME,
		SCAN_SKIP,
		SCAN_VALUE,
		SCAN_FINAL_LF,
		SCAN_HALT
	} scan_phase_t;

	typedef struct {
		hhfs_pkg::event_t    ev;
		hhfs_pkg::pair_rec_t rec;
	} line_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;   // [7:0] byte_in
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	// [15:0] name_start, [31:16] name_stop, [32] has_colon,
	// [48:33] value_start, [64:49] value_stop, [71:65] zero
	logic [hhfs_pkg::TDATA_W-1:0] m_axis_tdata;
	logic [2:0]         m_axis_tuser;           // [2:0] event_res
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_data = 8'h00;       // [7:0] max_space_run

	// scanner model state
	scan_phase_t scan_ph = SCAN_EXPECT_LF;
	logic [15:0] byte_pos = '0;
	logic [15:0] name_at = '0;
	logic [15:0] colon_at = '0;
	logic        colon_flag = 1'b0;
	logic [15:0] value_at = '0;
	int          blank_run = 0;
	logic [7:0]  space_limit = 8'(hhfs_pkg::MAX_RUN_DEFAULT);

	logic [7:0]   header_bytes[$];
	line_result_t expected_lines[$];
	int           stream_len = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           cfg_writes = 0;
	int           errors = 0;
	int           cycle_count = 0;
	bit           byte_taken = 1'b0;

	http_header_field_scanner DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Closes the current line at its CR and returns the pair record.
	function automatic hhfs_pkg::pair_rec_t close_line(input logic [15:0] cr_at);
		hhfs_pkg::pair_rec_t r;
		r = '0;
		r.name_start = name_at;
		r.name_stop = colon_flag ? colon_at : 16'h0;
		r.has_colon = colon_flag;
		r.value_start = colon_flag ? value_at : 16'h0;
		r.value_stop = cr_at;
		name_at = '0;
		colon_at = '0;
		colon_flag = 1'b0;
		value_at = '0;
		blank_run = 0;
		scan_ph = SCAN_EXPECT_LF;
		return r;
	endfunction

	task automatic scan_byte(input logic [7:0] b);
		logic [15:0]  here;
		line_result_t r;
		bit           emit;
		here = byte_pos;
		byte_pos = byte_pos + 16'd1;
		r.ev = hhfs_pkg::EV_PAIR;
		r.rec = '0;
		emit = 1'b0;
		case (scan_ph)
			SCAN_EXPECT_LF: begin
				if (b == hhfs_pkg::CH_LF) begin
					scan_ph = SCAN_AFTER_LF;
				end else begin
					r.ev = hhfs_pkg::EV_NO_LF;
					emit = 1'b1;
					scan_ph = SCAN_HALT;
				end
			end
			SCAN_AFTER_LF: begin
				if (b == hhfs_pkg::CH_CR) begin
					scan_ph = SCAN_FINAL_LF;
				end else begin
					// first name byte counts as name even when it is a colon
					name_at = here;
					scan_ph = SCAN_NAME;
				end
			end
			SCAN_NAME: begin
				if (b == hhfs_pkg::CH_CR) begin
					r.rec = close_line(here);
					emit = 1'b1;
				end else if (b == hhfs_pkg::CH_COLON) begin
					colon_at = here;
					colon_flag = 1'b1;
					blank_run = 0;
					scan_ph = SCAN_SKIP;
				end
			end
			SCAN_SKIP: begin
				if (b == hhfs_pkg::CH_SPACE || b == hhfs_pkg::CH_TAB) begin
					if (blank_run + 1 > int'(space_limit)) begin
						r.ev = hhfs_pkg::EV_SPACES;
						emit = 1'b1;
						scan_ph = SCAN_HALT;
					end else begin
						blank_run = blank_run + 1;
					end
				end else begin
					value_at = here;
					if (b == hhfs_pkg::CH_CR) begin
						r.rec = close_line(here);
						emit = 1'b1;
					end else begin
						scan_ph = SCAN_VALUE;
					end
				end
			end
			SCAN_VALUE: begin
				if (b == hhfs_pkg::CH_CR) begin
					r.rec = close_line(here);
					emit = 1'b1;
				end
			end
			SCAN_FINAL_LF: begin
				r.ev = (b == hhfs_pkg::CH_LF) ? hhfs_pkg::EV_END : hhfs_pkg::EV_NO_FINAL_LF;
				emit = 1'b1;
				scan_ph = SCAN_HALT;
			end
			default: ;
		endcase
		if (emit)
			expected_lines.push_back(r);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// Sample all handshakes at the rising edge.
	always @(posedge clk) begin : monitor
		line_result_t        want;
		hhfs_pkg::pair_rec_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_lines.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, got event %0d tdata %0h",
						$time, m_axis_tuser, m_axis_tdata);
				end else begin
					want = expected_lines.pop_front();
					got = m_axis_tdata;
					check_field("event_res", 32'(want.ev), 32'(m_axis_tuser));
					check_field("name_start", 32'(want.rec.name_start), 32'(got.name_start));
					check_field("name_stop", 32'(want.rec.name_stop), 32'(got.name_stop));
					check_field("has_colon", 32'(want.rec.has_colon), 32'(got.has_colon));
					check_field("value_start", 32'(want.rec.value_start),
						32'(got.value_start));
					check_field("value_stop", 32'(want.rec.value_stop), 32'(got.value_stop));
					check_field("pad", 32'(want.rec.pad), 32'(got.pad));
				end
			end
			byte_taken = s_axis_tvalid && s_axis_tready;
			if (byte_taken)
				scan_byte(s_axis_tdata);
			if (cfg_valid && cfg_ready) begin
				space_limit = cfg_data;
				cfg_writes++;
			end
		end
	end

	// Byte driver and receiver backpressure, both on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || byte_taken) begin
				if (header_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= header_bytes.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		header_bytes.push_back(b);
		stream_len++;
	endtask

	function automatic logic [7:0] rand_byte(input bit no_colon, input bit no_blank);
		logic [7:0] b;
		do begin
			if ($urandom_range(9) < 3) begin
				case ($urandom_range(5))
					0: b = hhfs_pkg::CH_LF;
					1: b = hhfs_pkg::CH_COLON;
					2: b = hhfs_pkg::CH_SPACE;
					3: b = hhfs_pkg::CH_TAB;
					4: b = 8'h00;
					default: b = 8'hFF;
				endcase
			end else begin
				b = 8'($urandom_range(255));
			end
		end while (b == hhfs_pkg::CH_CR || (no_colon && b == hhfs_pkg::CH_COLON) ||
			(no_blank && (b == hhfs_pkg::CH_SPACE || b == hhfs_pkg::CH_TAB)));
		return b;
	endfunction

	task automatic push_blanks(input int n);
		repeat (n) push_byte($urandom_range(1) ? hhfs_pkg::CH_SPACE : hhfs_pkg::CH_TAB);
	endtask

	// One well-formed line: LF, name, optional colon, blanks and value, CR.
	task automatic add_line(input int limit, input int value_len);
		int run;
		push_byte(hhfs_pkg::CH_LF);
		push_byte(rand_byte(1'b0, 1'b0));
		repeat ($urandom_range(0, 6)) push_byte(rand_byte(1'b1, 1'b0));
		if ($urandom_range(19) > 2) begin
			push_byte(hhfs_pkg::CH_COLON);
			if (limit == 0) begin
				run = 0;
			end else begin
				case ($urandom_range(15))
					0: run = limit;
					1, 2, 3, 4, 5: run = 0;
					default: run = $urandom_range(1, (limit < 4) ? limit : 4);
				endcase
			end
			push_blanks(run);
			if (value_len > 0) begin
				push_byte(rand_byte(1'b0, 1'b1));
				repeat (value_len - 1) push_byte(rand_byte(1'b0, 1'b0));
			end
		end
		push_byte(hhfs_pkg::CH_CR);
	endtask

	// Sender holds off until every byte is in and every item is out.
	task automatic drain;
		while (header_bytes.size() != 0 || s_axis_tvalid || expected_lines.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk); while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int         idle_pct[4];
		int         stall_pct[4];
		int         limit;
		int         phase_start;
		int         ending;
		logic [7:0] b;

		idle_pct = '{0, 86, 0, 35};
		stall_pct = '{0, 0, 86, 35};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines under the reset limit
		push_byte(hhfs_pkg::CH_LF);
		push_byte(hhfs_pkg::CH_COLON);
		push_byte("x");
		push_byte(hhfs_pkg::CH_COLON);
		push_byte(hhfs_pkg::CH_SPACE);
		push_byte(hhfs_pkg::CH_TAB);
		push_byte("v");
		push_byte(hhfs_pkg::CH_CR);
		push_byte(hhfs_pkg::CH_LF);  // no colon
		push_byte("n");
		push_byte(hhfs_pkg::CH_CR);
		push_byte(hhfs_pkg::CH_LF);  // empty value
		push_byte("k");
		push_byte(hhfs_pkg::CH_COLON);
		push_byte(hhfs_pkg::CH_CR);
		push_byte(hhfs_pkg::CH_LF);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(hhfs_pkg::CH_COLON);
		push_byte(8'h7F);
		push_byte(8'h80);
		push_byte(hhfs_pkg::CH_CR);
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: limit = 255;
				1: limit = 1;
				2: limit = $urandom_range(2, 254);
				default: begin
					case ($urandom_range(3))
						0: limit = 0;
						1: limit = 1;
						2: limit = 255;
						default: limit = $urandom_range(2, 254);
					endcase
				end
			endcase
			write_limit(8'(limit));
			send_idle_pct = idle_pct[p];
			recv_stall_pct = stall_pct[p];

			phase_start = stream_len;
			while (stream_len - phase_start < 320)
				add_line(limit, $urandom_range(0, 8));

			if (p == 3) begin
				ending = $urandom_range(3);
				case (ending)
					0: begin
						push_byte(hhfs_pkg::CH_LF);
						push_byte(hhfs_pkg::CH_CR);
						push_byte(hhfs_pkg::CH_LF);
					end
					1: begin
						push_byte(hhfs_pkg::CH_LF);
						push_byte(hhfs_pkg::CH_CR);
						do b = 8'($urandom_range(255)); while (b == hhfs_pkg::CH_LF);
						push_byte(b);
					end
					2: begin
						do b = 8'($urandom_range(255)); while (b == hhfs_pkg::CH_LF);
						push_byte(b);
					end
					default: begin
						push_byte(hhfs_pkg::CH_LF);
						push_byte("h");
						push_byte(hhfs_pkg::CH_COLON);
						push_blanks(limit + 1);
					end
				endcase
				// block is halted now; these bytes must produce nothing
				repeat (20) push_byte(8'($urandom_range(255)));
			end
			drain();
		end

		repeat (20) @(negedge clk);
		if (errors == 0 && expected_lines.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
